>>> rtl/clhl_pkg.sv
// package: modes, kinds, constants and character class helpers for the line lexer
package clhl_pkg;

  localparam int MaxLineTokens = 64;
  localparam int MaxColumns    = 65535;
  localparam int EmitW         = $clog2(MaxLineTokens + 1);

  typedef enum logic [3:0] {
    M_LEAD, M_NORMAL, M_SLASH, M_LINECOM, M_BLOCKCOM,
    M_STRING, M_CHARLIT, M_NUMBER, M_IDENT, M_PREPROC
  } mode_t;

  typedef enum logic [2:0] {
    P_INT, P_ZERO, P_HEX, P_FRAC, P_EXP_START, P_EXP_SIGN, P_EXP_DIGITS, P_SUFFIX
  } phase_t;

  localparam logic [2:0] K_KEYWORD = 3'd0;
  localparam logic [2:0] K_TYPE    = 3'd1;
  localparam logic [2:0] K_STRING  = 3'd2;
  localparam logic [2:0] K_CHAR    = 3'd3;
  localparam logic [2:0] K_NUMBER  = 3'd4;
  localparam logic [2:0] K_COMMENT = 3'd5;
  localparam logic [2:0] K_PREPROC = 3'd6;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  // one token produced by the scanner
  typedef struct packed {
    logic        vld;
    logic [15:0] start;
    logic [15:0] length;
    logic [2:0]  kind;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return c == "e" || c == "E" || c == "p" || c == "P";
  endfunction

  // pack a word, low byte first, zero padded to 8 bytes
  function automatic logic [63:0] pk(input string s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  // 0 none, 1 keyword, 2 type word
  function automatic logic [1:0] word_class(input logic [63:0] w, input logic [3:0] n);
    logic [1:0] r;
    r = 2'd0;
    case (n)
      4'd2: if (w == pk("do") || w == pk("if")) r = 2'd1;
      4'd3: if (w == pk("for")) r = 2'd1;
            else if (w == pk("int")) r = 2'd2;
      4'd4: if (w == pk("auto") || w == pk("case") || w == pk("else") || w == pk("enum") ||
                w == pk("goto")) r = 2'd1;
            else if (w == pk("char") || w == pk("long") || w == pk("void")) r = 2'd2;
      4'd5: if (w == pk("break") || w == pk("const") || w == pk("union") ||
                w == pk("while")) r = 2'd1;
            else if (w == pk("_Bool") || w == pk("float") || w == pk("short")) r = 2'd2;
      4'd6: if (w == pk("extern") || w == pk("return") || w == pk("sizeof") ||
                w == pk("static") || w == pk("struct") || w == pk("switch")) r = 2'd1;
            else if (w == pk("double") || w == pk("signed")) r = 2'd2;
      4'd7: if (w == pk("default") || w == pk("typedef")) r = 2'd1;
            else if (w == pk("_Atomic")) r = 2'd2;
      4'd8: if (w == pk("continue") || w == pk("register") || w == pk("restrict") ||
                w == pk("volatile")) r = 2'd1;
            else if (w == pk("_Complex") || w == pk("unsigned")) r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/clhl_if.sv
// valid/ready channel interfaces for characters and tokens
interface clhl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;
  modport source (output valid, ch, line_end, input ready);
  modport sink   (input valid, ch, line_end, output ready);
endinterface

interface clhl_tok_if;
  logic        valid;
  logic        ready;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [2:0]  token_kind;
  logic        last_in_run;
  modport source (output valid, token_start, token_length, token_kind, last_in_run,
                  input ready);
  modport sink   (input valid, token_start, token_length, token_kind, last_in_run,
                  output ready);
endinterface

>>> rtl/clhl_scan.sv
// scanner: per-character lexer state update producing up to two tokens
module clhl_scan import clhl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       line_end,
  output tok_t       tok0,
  output tok_t       tok1
);

  mode_t              mode;
  logic [15:0]        column;
  logic [15:0]        tbeg;
  logic [63:0]        wbuf;
  logic [3:0]         wcnt;
  phase_t             phase;
  logic               seen;
  logic [EmitW-1:0]   emitted;

  mode_t              mode_next;
  logic [15:0]        tbeg_next;
  logic [63:0]        wbuf_next;
  logic [3:0]         wcnt_next;
  phase_t             phase_next;
  logic               seen_next;
  logic [EmitW-1:0]   emitted_next;

  // combinational scan of one character
  always_comb begin
    logic        again;
    logic [16:0] col;
    logic [16:0] endp;
    logic        ev [2];
    logic [16:0] es [2];
    logic [16:0] ee [2];
    logic [2:0]  ek [2];
    logic [1:0]  ne;
    logic [1:0]  wc;
    phase_t      p;
    logic        act;
    mode_next  = mode;
    tbeg_next  = tbeg;
    wbuf_next  = wbuf;
    wcnt_next  = wcnt;
    phase_next = phase;
    seen_next  = seen;
    col  = {1'b0, column};
    endp = '0;
    ne   = '0;
    again = 1'b0;
    p    = phase;
    wc   = 2'd0;
    act  = column < 16'(MaxColumns);
    for (int i = 0; i < 2; i++) begin
      ev[i] = 1'b0; es[i] = '0; ee[i] = '0; ek[i] = K_KEYWORD;
    end
    // first pass in the current mode
    if (act) begin
      case (mode)
        M_LEAD: begin
          if (ch == " " || ch == 8'h09) begin
          end else if (ch == CH_HASH) begin
            mode_next = M_PREPROC;
            tbeg_next = column;
          end else begin
            mode_next = M_NORMAL;
            again = 1'b1;
          end
        end
        M_SLASH: begin
          if (ch == "/") mode_next = M_LINECOM;
          else if (ch == "*") begin
            mode_next = M_BLOCKCOM;
            seen_next = 1'b0;
          end else begin
            mode_next = M_NORMAL;
            again = 1'b1;
          end
        end
        M_LINECOM, M_PREPROC: begin
        end
        M_BLOCKCOM: begin
          if (seen && ch == "/") begin
            ev[0] = 1'b1; es[0] = {1'b0, tbeg}; ee[0] = col + 17'd1; ek[0] = K_COMMENT;
            mode_next = M_NORMAL;
            seen_next = 1'b0;
          end else seen_next = (ch == "*");
        end
        M_STRING, M_CHARLIT: begin
          if (seen) seen_next = 1'b0;
          else if (ch == CH_BSL) seen_next = 1'b1;
          else if (ch == ((mode == M_STRING) ? 8'h22 : 8'h27)) begin
            ev[0] = 1'b1; es[0] = {1'b0, tbeg}; ee[0] = col + 17'd1;
            ek[0] = (mode == M_STRING) ? K_STRING : K_CHAR;
            mode_next = M_NORMAL;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
            if (wcnt < 4'd8) wbuf_next[8*wcnt[2:0] +: 8] = ch;
            if (wcnt < 4'd9) wcnt_next = wcnt + 4'd1;
          end else begin
            wc = word_class(wbuf, wcnt);
            ev[0] = wc != 2'd0; es[0] = {1'b0, tbeg}; ee[0] = col;
            ek[0] = (wc == 2'd2) ? K_TYPE : K_KEYWORD;
            mode_next = M_NORMAL;
            again = 1'b1;
          end
        end
        M_NUMBER: begin
          if (phase == P_ZERO) p = P_INT;
          if (phase == P_ZERO && (ch == "x" || ch == "X")) phase_next = P_HEX;
          else if ((p == P_INT || p == P_FRAC || p == P_EXP_DIGITS) && is_digit(ch))
            phase_next = p;
          else if (p == P_HEX && is_xdigit(ch)) begin
          end else if (p == P_INT && ch == ".") phase_next = P_FRAC;
          else if ((p == P_INT || p == P_FRAC || p == P_HEX) && is_exp(ch))
            phase_next = P_EXP_START;
          else if (p == P_EXP_START && (ch == "+" || ch == "-")) phase_next = P_EXP_SIGN;
          else if ((p == P_EXP_START || p == P_EXP_SIGN) && is_digit(ch))
            phase_next = P_EXP_DIGITS;
          else if (p != P_EXP_SIGN && is_alpha(ch)) phase_next = P_SUFFIX;
          else begin
            ev[0] = 1'b1; es[0] = {1'b0, tbeg};
            ee[0] = (p == P_EXP_SIGN) ? col - 17'd1 : col; ek[0] = K_NUMBER;
            mode_next = M_NORMAL;
            phase_next = P_INT;
            again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase
      // fresh scan in normal mode
      if (again) begin
        mode_next = M_NORMAL;
        tbeg_next = column;
        if (ch == "/") mode_next = M_SLASH;
        else if (ch == 8'h22) begin
          mode_next = M_STRING; seen_next = 1'b0;
        end else if (ch == 8'h27) begin
          mode_next = M_CHARLIT; seen_next = 1'b0;
        end else if (is_digit(ch)) begin
          mode_next = M_NUMBER;
          phase_next = (ch == "0") ? P_ZERO : P_INT;
        end else if (is_alpha(ch) || ch == CH_UNDER) begin
          mode_next = M_IDENT;
          wbuf_next = {56'd0, ch};
          wcnt_next = 4'd1;
        end
      end
    end
    // line end closes whatever is open
    if (line_end) begin
      endp = act ? col + 17'd1 : 17'(MaxColumns);
      es[1] = {1'b0, tbeg_next}; ee[1] = endp;
      case (mode_next)
        M_PREPROC: begin ev[1] = 1'b1; ek[1] = K_PREPROC; end
        M_LINECOM, M_BLOCKCOM: begin ev[1] = 1'b1; ek[1] = K_COMMENT; end
        M_STRING: begin ev[1] = 1'b1; ek[1] = K_STRING; end
        M_CHARLIT: begin ev[1] = 1'b1; ek[1] = K_CHAR; end
        M_NUMBER: begin
          ev[1] = 1'b1; ek[1] = K_NUMBER;
          if (phase_next == P_EXP_SIGN) ee[1] = endp - 17'd1;
        end
        M_IDENT: begin
          wc = word_class(wbuf_next, wcnt_next);
          ev[1] = wc != 2'd0; ek[1] = (wc == 2'd2) ? K_TYPE : K_KEYWORD;
        end
        default: ev[1] = 1'b0;
      endcase
    end
    // token limit and empty-span filter, packed in order
    emitted_next = emitted;
    tok0 = '0;
    tok1 = '0;
    for (int i = 0; i < 2; i++) begin
      if (step && ev[i] && ee[i] > es[i] && emitted_next < EmitW'(MaxLineTokens)) begin
        emitted_next = emitted_next + EmitW'(1);
        if (ne == 2'd0) tok0 = '{1'b1, es[i][15:0], 16'(ee[i] - es[i]), ek[i]};
        else tok1 = '{1'b1, es[i][15:0], 16'(ee[i] - es[i]), ek[i]};
        ne = ne + 2'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst || (step && line_end)) begin
      mode    <= M_LEAD;
      column  <= '0;
      tbeg    <= '0;
      wbuf    <= '0;
      wcnt    <= '0;
      phase   <= P_INT;
      seen    <= 1'b0;
      emitted <= '0;
    end else if (step) begin
      mode    <= mode_next;
      tbeg    <= tbeg_next;
      wbuf    <= wbuf_next;
      wcnt    <= wcnt_next;
      phase   <= phase_next;
      seen    <= seen_next;
      emitted <= emitted_next;
      if (column < 16'(MaxColumns)) column <= column + 16'd1;
    end
  end

endmodule

>>> rtl/clhl_outq.sv
// output stage: holds up to two tokens and hands them out one per transfer
module clhl_outq import clhl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  tok_t   in0,
  input  tok_t   in1,
  input  logic   load,
  output logic   can_load,
  clhl_tok_if.source tok
);

  tok_t slot0, slot1;

  // accept new pair when empty or the last held token leaves now
  assign can_load = !slot0.vld || (!slot1.vld && tok.ready);

  assign tok.valid        = slot0.vld;
  assign tok.token_start  = slot0.start;
  assign tok.token_length = slot0.length;
  assign tok.token_kind   = slot0.kind;
  assign tok.last_in_run  = !slot1.vld;

  // shift on transfer, refill on load
  always_ff @(posedge clk) begin
    if (rst) begin
      slot0.vld <= 1'b0;
      slot1.vld <= 1'b0;
    end else if (load) begin
      if (in0.vld) begin
        slot0 <= in0;
        slot1 <= in1;
      end else begin
        slot0.vld <= 1'b0;
        slot1.vld <= 1'b0;
      end
    end else if (tok.valid && tok.ready) begin
      slot0 <= slot1;
      slot1.vld <= 1'b0;
    end
  end

endmodule

>>> rtl/c_line_highlight_lexer.sv
// top level of the C line highlight lexer
// channel | dir | fields
// chr     | in  | ch[7:0], line_end
// tok     | out | token_start[15:0], token_length[15:0], token_kind[2:0], last_in_run
// one character per cycle while the output can take it; each character is scanned in the cycle it transfers
// and its zero to two tokens sit in a two-slot output register the next cycle
// a character is taken while the output holds at most one token that leaves now
// rst is synchronous and clears lexer state and the output slots
module c_line_highlight_lexer import clhl_pkg::*; (
  input  logic clk,
  input  logic rst,
  clhl_char_if.sink   chr,
  clhl_tok_if.source  tok
);

  tok_t t0, t1;
  logic can_load;
  logic step;

  assign chr.ready = can_load;
  assign step      = chr.valid && can_load;

  // lexer
  clhl_scan u_scan (
    .clk, .rst, .step, .ch(chr.ch), .line_end(chr.line_end), .tok0(t0), .tok1(t1)
  );

  // output slots
  clhl_outq u_outq (
    .clk, .rst, .in0(t0), .in1(t1), .load(step), .can_load, .tok
  );

endmodule

>>> rtl/clhl_check.sv
// port checker for the lexer, bound to the top level
module clhl_check import clhl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] token_length,
  input logic [2:0]  token_kind,
  input logic        last_in_run
);

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_length != 16'd0) else $error("zero length token");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= K_PREPROC) else $error("bad token kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_length))
    else $error("stalled token changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_in_run |-> !in_ready) else $error("input taken with two tokens held");

endmodule

bind c_line_highlight_lexer clhl_check u_check (
  .clk, .rst, .in_ready(chr.ready),
  .out_valid(tok.valid), .out_ready(tok.ready), .token_length(tok.token_length),
  .token_kind(tok.token_kind), .last_in_run(tok.last_in_run)
);
